### rtl/core/okm_pkg.sv
// Package for the online three-means clusterer.
// Holds default sizes, fixed field widths and the controller/datapath structs.
// No dependencies.
package okm_pkg;

    localparam int NUM_CLUSTERS_DEF = 3;
    localparam int COORD_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int POINT_W  = 16;
    localparam int INDEX_W  = 2;
    localparam int CENTRE_W = 16;
    localparam int COUNT_W  = 16;

    typedef struct packed {
        logic load_point;
        logic seed;
        logic scan_mul;
        logic scan_cmp;
        logic check_sat;
        logic div_start;
        logic div_write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic seeding;
        logic scan_last;
        logic saturated;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

### rtl/core/okm_point_if.sv
// Point channel interface: valid, ready and the two coordinates.
// Depends on okm_pkg for the field width.
interface okm_point_if;
    import okm_pkg::*;

    logic               valid;
    logic               ready;
    logic [POINT_W-1:0] point_x;
    logic [POINT_W-1:0] point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

### rtl/core/okm_result_if.sv
// Result channel interface: valid, ready and the cluster report fields.
// Depends on okm_pkg for the field widths.
interface okm_result_if;
    import okm_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  cluster_index;
    logic [CENTRE_W-1:0] centre_x;
    logic [CENTRE_W-1:0] centre_y;
    logic [COUNT_W-1:0]  member_count;
    logic                was_seed;

    modport source (output valid, cluster_index, centre_x, centre_y, member_count, was_seed,
                    input ready);
    modport sink   (input valid, cluster_index, centre_x, centre_y, member_count, was_seed,
                    output ready);
endinterface

### rtl/core/online_three_means_clusterer.sv
// Top level of the online three-means clusterer: controller plus datapath.
// Depends on okm_pkg, okm_point_if, okm_result_if, okm_ctrl and okm_dpath.
//
//  Channel   Direction  Payload
//  i_point   in         point_x, point_y
//  o_result  out        cluster_index, centre_x, centre_y, member_count, was_seed
//
// A seeding point passes from S_SEED to S_OUT before its result is ready.
// A clustered point runs the distance scan (S_MUL, S_CMP for each cluster), then S_CHECK,
// and waits in S_DIV on the two bit-serial dividers that form the new mean.
// A point that finds its cluster saturated goes from S_CHECK straight to S_OUT.
// Reset is synchronous and active low; it clears the seed count and the control state.
// One point is worked on at a time; a stalled result holds in the output register.
module online_three_means_clusterer #(
    parameter int NUM_CLUSTERS = okm_pkg::NUM_CLUSTERS_DEF,
    parameter int COORD_BITS   = okm_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS   = okm_pkg::COUNT_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    okm_point_if.sink      i_point,
    okm_result_if.source   o_result
);
    import okm_pkg::*;

    t_cmd    cmd;
    t_status status;

    okm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_point.valid),
        .o_in_ready (i_point.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    okm_dpath #(
        .NUM_CLUSTERS (NUM_CLUSTERS),
        .COORD_BITS   (COORD_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_point_x       (i_point.point_x),
        .i_point_y       (i_point.point_y),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_cluster_index (o_result.cluster_index),
        .o_centre_x      (o_result.centre_x),
        .o_centre_y      (o_result.centre_y),
        .o_member_count  (o_result.member_count),
        .o_was_seed      (o_result.was_seed)
    );
endmodule

### rtl/core/okm_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Standalone; used by okm_dpath for the centre means.
module okm_div #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output logic [NUM_BITS-1:0] o_quotient,
    output logic                o_busy
);
    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_num, n_num;
    logic [DEN_BITS-1:0] r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DEN_BITS:0]   rem_shift;
    logic [DEN_BITS:0]   rem_diff;
    logic                rem_ge;

    always_comb begin
        rem_shift = {r_rem, r_num[NUM_BITS-1]};
        rem_diff  = rem_shift - {1'b0, r_den};
        rem_ge    = rem_shift >= {1'b0, r_den};
        n_num     = r_num;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        if (i_start) begin
            n_num = i_dividend;
            n_rem = '0;
            n_cnt = CNT_W'(NUM_BITS);
        end else if (r_cnt != '0) begin
            n_num = {r_num[NUM_BITS-2:0], rem_ge};
            n_rem = rem_ge ? rem_diff[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_divisor;
        end
    end

    assign o_quotient = r_num;
    assign o_busy     = r_cnt != '0;
endmodule

### rtl/core/okm_ctrl.sv
// Controller state machine for the clusterer.
// Depends on okm_pkg for the command and status structs.
module okm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  okm_pkg::t_status i_status,
    output okm_pkg::t_cmd   o_cmd
);
    import okm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SEED  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_point = 1'b1;
                    n_state = i_status.seeding ? S_SEED : S_MUL;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state = S_OUT;
            end
            S_MUL: begin
                o_cmd.scan_mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state = i_status.scan_last ? S_CHECK : S_MUL;
            end
            S_CHECK: begin
                if (i_status.saturated) begin
                    o_cmd.check_sat = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.div_write = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule

### rtl/core/okm_dpath.sv
// Datapath for the clusterer: cluster state, distance scan, dividers and output register.
// Depends on okm_pkg and okm_div.
module okm_dpath #(
    parameter int NUM_CLUSTERS = okm_pkg::NUM_CLUSTERS_DEF,
    parameter int COORD_BITS   = okm_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS   = okm_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  okm_pkg::t_cmd                 i_cmd,
    output okm_pkg::t_status              o_status,
    input  logic [okm_pkg::POINT_W-1:0]   i_point_x,
    input  logic [okm_pkg::POINT_W-1:0]   i_point_y,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [okm_pkg::INDEX_W-1:0]   o_cluster_index,
    output logic [okm_pkg::CENTRE_W-1:0]  o_centre_x,
    output logic [okm_pkg::CENTRE_W-1:0]  o_centre_y,
    output logic [okm_pkg::COUNT_W-1:0]   o_member_count,
    output logic                          o_was_seed
);
    import okm_pkg::*;

    localparam int IDX_W  = $clog2(NUM_CLUSTERS);
    localparam int SEED_W = $clog2(NUM_CLUSTERS + 1);
    localparam int SUM_W  = COORD_BITS + COUNT_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DST_W  = SQ_W + 1;

    logic [COORD_BITS-1:0] r_cx  [NUM_CLUSTERS];
    logic [COORD_BITS-1:0] r_cy  [NUM_CLUSTERS];
    logic [SUM_W-1:0]      r_sx  [NUM_CLUSTERS];
    logic [SUM_W-1:0]      r_sy  [NUM_CLUSTERS];
    logic [COUNT_BITS-1:0] r_cnt [NUM_CLUSTERS];

    logic [SEED_W-1:0]     r_seeds;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [IDX_W-1:0]      r_k, r_best;
    logic [SQ_W-1:0]       r_sqx, r_sqy;
    logic [DST_W-1:0]      r_best_d;

    logic [IDX_W-1:0]      r_res_idx;
    logic [COORD_BITS-1:0] r_res_cx, r_res_cy;
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic                  r_res_seed;

    logic                  r_out_valid;
    logic [INDEX_W-1:0]    r_out_idx;
    logic [CENTRE_W-1:0]   r_out_cx, r_out_cy;
    logic [COUNT_W-1:0]    r_out_cnt;
    logic                  r_out_seed;

    logic [IDX_W-1:0]      rd_idx, seed_idx;
    logic [COORD_BITS-1:0] rd_cx, rd_cy, dx, dy;
    logic [SUM_W-1:0]      rd_sx, rd_sy, new_sx, new_sy;
    logic [COUNT_BITS-1:0] rd_cnt, new_cnt;
    logic [DST_W-1:0]      sq_dist;
    logic [SUM_W-1:0]      quo_x, quo_y;
    logic                  busy_x, busy_y;
    logic                  saturated;

    assign seed_idx  = r_seeds[IDX_W-1:0];
    assign rd_idx    = (i_cmd.scan_mul) ? r_k : r_best;
    assign rd_cx     = r_cx[rd_idx];
    assign rd_cy     = r_cy[rd_idx];
    assign rd_sx     = r_sx[rd_idx];
    assign rd_sy     = r_sy[rd_idx];
    assign rd_cnt    = r_cnt[rd_idx];
    assign dx        = (rd_cx >= r_px) ? rd_cx - r_px : r_px - rd_cx;
    assign dy        = (rd_cy >= r_py) ? rd_cy - r_py : r_py - rd_cy;
    assign sq_dist   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign saturated = rd_cnt == {COUNT_BITS{1'b1}};
    assign new_sx    = rd_sx + SUM_W'(r_px);
    assign new_sy    = rd_sy + SUM_W'(r_py);
    assign new_cnt   = rd_cnt + COUNT_BITS'(1);

    okm_div #(.NUM_BITS(SUM_W), .DEN_BITS(COUNT_BITS)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (new_sx),
        .i_divisor  (new_cnt),
        .o_quotient (quo_x),
        .o_busy     (busy_x)
    );

    okm_div #(.NUM_BITS(SUM_W), .DEN_BITS(COUNT_BITS)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (new_sy),
        .i_divisor  (new_cnt),
        .o_quotient (quo_y),
        .o_busy     (busy_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeds     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.seed) begin
                r_seeds <= r_seeds + SEED_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd.load_point) begin
            r_px <= COORD_BITS'(i_point_x);
            r_py <= COORD_BITS'(i_point_y);
            r_k  <= '0;
        end

        if (i_cmd.seed) begin
            r_cx[seed_idx]  <= r_px;
            r_cy[seed_idx]  <= r_py;
            r_sx[seed_idx]  <= SUM_W'(r_px);
            r_sy[seed_idx]  <= SUM_W'(r_py);
            r_cnt[seed_idx] <= COUNT_BITS'(1);
            r_res_idx       <= seed_idx;
            r_res_cx        <= r_px;
            r_res_cy        <= r_py;
            r_res_cnt       <= COUNT_BITS'(1);
            r_res_seed      <= 1'b1;
        end

        if (i_cmd.scan_mul) begin
            r_sqx <= dx * dx;
            r_sqy <= dy * dy;
        end

        if (i_cmd.scan_cmp) begin
            if (r_k == '0 || sq_dist < r_best_d) begin
                r_best   <= r_k;
                r_best_d <= sq_dist;
            end
            r_k <= r_k + IDX_W'(1);
        end

        if (i_cmd.check_sat) begin
            r_res_idx  <= r_best;
            r_res_cx   <= rd_cx;
            r_res_cy   <= rd_cy;
            r_res_cnt  <= rd_cnt;
            r_res_seed <= 1'b0;
        end

        if (i_cmd.div_start) begin
            r_sx[r_best]  <= new_sx;
            r_sy[r_best]  <= new_sy;
            r_cnt[r_best] <= new_cnt;
            r_res_idx     <= r_best;
            r_res_cnt     <= new_cnt;
            r_res_seed    <= 1'b0;
        end

        if (i_cmd.div_write) begin
            r_cx[r_best] <= quo_x[COORD_BITS-1:0];
            r_cy[r_best] <= quo_y[COORD_BITS-1:0];
            r_res_cx     <= quo_x[COORD_BITS-1:0];
            r_res_cy     <= quo_y[COORD_BITS-1:0];
        end

        if (i_cmd.out_load) begin
            r_out_idx  <= INDEX_W'(r_res_idx);
            r_out_cx   <= CENTRE_W'(r_res_cx);
            r_out_cy   <= CENTRE_W'(r_res_cy);
            r_out_cnt  <= COUNT_W'(r_res_cnt);
            r_out_seed <= r_res_seed;
        end
    end

    always_comb begin
        o_status.seeding   = r_seeds < SEED_W'(NUM_CLUSTERS);
        o_status.scan_last = r_k == IDX_W'(NUM_CLUSTERS - 1);
        o_status.saturated = saturated;
        o_status.div_done  = !(busy_x || busy_y);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_cluster_index = r_out_idx;
    assign o_centre_x      = r_out_cx;
    assign o_centre_y      = r_out_cy;
    assign o_member_count  = r_out_cnt;
    assign o_was_seed      = r_out_seed;

    a_seeds_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeds <= SEED_W'(NUM_CLUSTERS))
        else $error("Seed count exceeds the number of clusters.");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("Output register loaded while a result still waits.");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (busy_x && busy_y))
        else $error("Dividers not busy after start.");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_mul |-> (r_k < IDX_W'(NUM_CLUSTERS) || NUM_CLUSTERS == (1 << IDX_W)))
        else $error("Scan index beyond the last cluster.");

    a_scan_only_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_mul |-> r_seeds == SEED_W'(NUM_CLUSTERS))
        else $error("Distance scan started before all clusters were seeded.");
endmodule

### tb/sv/tb_online_three_means_clusterer.sv
// Self-checking testbench for the online three-means clusterer.
// Points go in through a queue-fed driver; a monitor checks each cluster report against a predictor.
// Depends on okm_pkg, okm_point_if, okm_result_if and the clusterer RTL at its default sizes.
`timescale 1ns / 100ps

module tb_online_three_means_clusterer;
    import okm_pkg::*;

    localparam int NUM_CL        = NUM_CLUSTERS_DEF;
    localparam int COORD_BITS_TB = COORD_BITS_DEF;
    localparam int COUNT_BITS_TB = COUNT_BITS_DEF;
    localparam longint unsigned MEMBER_MAX = (64'd1 << COUNT_BITS_TB) - 1;
    localparam int LATENCY       = 2 * NUM_CL + COORD_BITS_TB + COUNT_BITS_TB + 4;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int RANDOM_POINTS = 1685;

    typedef struct packed {
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [INDEX_W-1:0]  cluster;
        logic [CENTRE_W-1:0] cx;
        logic [CENTRE_W-1:0] cy;
        logic [COUNT_W-1:0]  count;
        logic                seed;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    okm_point_if  point_ch ();
    okm_result_if result_ch ();

    online_three_means_clusterer #(
        .NUM_CLUSTERS (NUM_CL),
        .COORD_BITS   (COORD_BITS_TB),
        .COUNT_BITS   (COUNT_BITS_TB)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (point_ch),
        .o_result (result_ch)
    );

    int                seeded;
    logic [15:0]       mean_x  [NUM_CL];
    logic [15:0]       mean_y  [NUM_CL];
    longint unsigned   total_x [NUM_CL];
    longint unsigned   total_y [NUM_CL];
    longint unsigned   members [NUM_CL];

    t_point  pending_points[$];
    t_report expected_reports[$];

    int error_count = 0;
    int send_gap    = 0;
    int send_calm   = 0;
    int recv_stall  = 0;
    int recv_calm   = 0;
    int idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        point_ch.valid = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        result_ch.ready = 1'b0;
        seeded = 0;
        for (int k = 0; k < NUM_CL; k++) begin
            mean_x[k] = '0;
            mean_y[k] = '0;
            total_x[k] = 0;
            total_y[k] = 0;
            members[k] = 0;
        end
    end

    always #4 i_clk = ~i_clk;

    function automatic t_report cluster_point(t_point p);
        t_report r;
        int best;
        longint unsigned dx, dy, d, best_d;
        best = 0;
        best_d = 0;
        if (seeded < NUM_CL) begin
            best = seeded;
            mean_x[best] = p.x;
            mean_y[best] = p.y;
            total_x[best] = p.x;
            total_y[best] = p.y;
            members[best] = 1;
            seeded++;
            r.seed = 1'b1;
        end else begin
            for (int k = 0; k < NUM_CL; k++) begin
                dx = (mean_x[k] >= p.x) ? longint'(mean_x[k] - p.x) : longint'(p.x - mean_x[k]);
                dy = (mean_y[k] >= p.y) ? longint'(mean_y[k] - p.y) : longint'(p.y - mean_y[k]);
                d = dx * dx + dy * dy;
                if (k == 0 || d < best_d) begin
                    best_d = d;
                    best = k;
                end
            end
            if (members[best] < MEMBER_MAX) begin
                total_x[best] += p.x;
                total_y[best] += p.y;
                members[best] += 1;
                mean_x[best] = 16'(total_x[best] / members[best]);
                mean_y[best] = 16'(total_y[best] / members[best]);
            end
            r.seed = 1'b0;
        end
        r.cluster = INDEX_W'(best);
        r.cx = mean_x[best];
        r.cy = mean_y[best];
        r.count = COUNT_W'(members[best]);
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm run with none at all.
    function automatic int draw_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_point near_point(int k, int spread);
        int px, py;
        t_point p;
        px = int'(mean_x[k]) + int'($urandom_range(0, 2 * spread)) - spread;
        py = int'(mean_y[k]) + int'($urandom_range(0, 2 * spread)) - spread;
        px = (px < 0) ? 0 : (px > 65535) ? 65535 : px;
        py = (py < 0) ? 0 : (py > 65535) ? 65535 : py;
        p.x = 16'(px);
        p.y = 16'(py);
        return p;
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic flag_error(string what);
        if (error_count < 40) $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_point(t_point p);
        while (pending_points.size() > 2) @(posedge i_clk);
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || point_ch.valid || expected_reports.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_point next_point;
        if (!i_rst_n) begin
            point_ch.valid <= 1'b0;
            send_gap = $urandom_range(0, 3);
        end else begin
            if (point_ch.valid && point_ch.ready) begin
                expected_reports.insert(expected_reports.size(),
                    cluster_point(t_point'{point_ch.point_x, point_ch.point_y}));
            end
            if (!point_ch.valid || point_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    point_ch.valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    next_point = pending_points.pop_front();
                    point_ch.valid <= 1'b1;
                    point_ch.point_x <= next_point.x;
                    point_ch.point_y <= next_point.y;
                    send_gap = draw_idle(send_calm);
                end else begin
                    point_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_report got, want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_stall = $urandom_range(0, 5);
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got.cluster = result_ch.cluster_index;
                got.cx = result_ch.centre_x;
                got.cy = result_ch.centre_y;
                got.count = result_ch.member_count;
                got.seed = result_ch.was_seed;
                if (expected_reports.size() == 0) begin
                    flag_error("result transfer with no point outstanding");
                end else begin
                    want = expected_reports.pop_front();
                    if (got.cluster !== want.cluster)
                        flag_error($sformatf("cluster_index got %0d want %0d",
                                             got.cluster, want.cluster));
                    if (got.cx !== want.cx)
                        flag_error($sformatf("centre_x got %h want %h", got.cx, want.cx));
                    if (got.cy !== want.cy)
                        flag_error($sformatf("centre_y got %h want %h", got.cy, want.cy));
                    if (got.count !== want.count)
                        flag_error($sformatf("member_count got %0d want %0d",
                                             got.count, want.count));
                    if (got.seed !== want.seed)
                        flag_error($sformatf("was_seed got %b want %b", got.seed, want.seed));
                end
                recv_stall = draw_idle(recv_calm);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (point_ch.valid && point_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_point p;
        int k;
        int r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The three seeds, then a point equidistant from all of them and one on the tie
        // line between clusters one and two, followed by the field extremes.
        queue_point('{16'h0000, 16'h0000});
        queue_point('{16'hFFFE, 16'h0000});
        queue_point('{16'h0000, 16'hFFFE});
        queue_point('{16'h7FFF, 16'h7FFF});
        queue_point('{16'hFFFF, 16'hFFFF});
        queue_point('{16'h0000, 16'h0000});
        queue_point('{16'hFFFF, 16'h0000});
        queue_point('{16'h0000, 16'hFFFF});
        queue_point('{16'hAAAA, 16'h5555});
        queue_point('{16'h5555, 16'hAAAA});
        queue_point('{16'h8000, 16'h7FFF});
        queue_point('{16'h7FFF, 16'h8000});
        queue_point('{16'h0001, 16'h0001});
        queue_point('{16'hFFFF, 16'hFFFE});
        queue_point('{16'h0010, 16'hFFF0});
        wait_drained();

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, NUM_CL - 1);
            if (r < 60) begin
                p = near_point(k, ($urandom_range(0, 4) == 0) ? 4095 : 255);
            end else if (r < 70) begin
                p.x = mean_x[k];
                p.y = mean_y[k];
            end else if (r < 90) begin
                p.x = 16'($urandom_range(0, 65535));
                p.y = 16'($urandom_range(0, 65535));
            end else begin
                p.x = corner_value();
                p.y = corner_value();
            end
            queue_point(p);
        end
        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);

        if (error_count == 0 && expected_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
